>>> rtl/core/tbpt_pkg.sv
// Shared types and constants of the touch button press tracker.
`default_nettype none

package tbpt_pkg;

	localparam int NUM_BUTTONS_DEF = 8;
	localparam int COORD_BITS_DEF  = 12;
	localparam int BTN_W           = 3;
	localparam int CMD_W           = 2;

	localparam logic [CMD_W-1:0] CMD_DEFINE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic write_slot;  // define item: write rectangle and enable
		logic load_item;   // touch or end-of-scan item: latch it, restart slot scan
		logic step;        // evaluate current slot and move on
		logic flush;       // send held event as the last one
		logic finish;      // item done
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ev;          // current slot produces an event
		logic hold_valid;  // an event waits in the hold register
		logic out_free;    // output register can take a transfer this cycle
		logic last_slot;   // scan is at the highest slot
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/touch_button_press_tracker.sv
// Touch button press tracker: top level joining controller and datapath.
//
// Holds NUM_BUTTONS button rectangles with enable, pressed and touched flags.
// A define item writes its slot while idle. A touch-point or end-of-scan item
// steps through the slots in ascending order, one per cycle unless the scan
// stalls, hit-testing or checking for release; no next item is accepted until
// the scan and its flush step are done. Every event of an item must move into
// the output register before the item ends, so the scan and the flush wait
// while that register is full and an event waits for it.
// Events leave through a registered output; the last event of an item has
// last_event set. Coordinates are COORD_BITS wide, bounds are half-open.
`default_nettype none

module touch_button_press_tracker #(
	parameter int NUM_BUTTONS = tbpt_pkg::NUM_BUTTONS_DEF,
	parameter int COORD_BITS  = tbpt_pkg::COORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [tbpt_pkg::CMD_W-1:0] cmd,
	input  wire logic [tbpt_pkg::BTN_W-1:0] button_index,
	input  wire logic [COORD_BITS-1:0]      touch_x,
	input  wire logic [COORD_BITS-1:0]      touch_y,
	input  wire logic [COORD_BITS-1:0]      rect_width,
	input  wire logic [COORD_BITS-1:0]      rect_height,
	input  wire logic                       slot_enabled,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            event_kind,
	output logic [tbpt_pkg::BTN_W-1:0]      event_button,
	output logic                            last_event
);
	import tbpt_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	tbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.status_i (dp_status),
		.cmd_o    (ctrl_cmd)
	);

	tbpt_dp #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_i        (ctrl_cmd),
		.status_o     (dp_status),
		.cmd          (cmd),
		.button_index (button_index),
		.touch_x      (touch_x),
		.touch_y      (touch_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.slot_enabled (slot_enabled),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.event_button (event_button),
		.last_event   (last_event)
	);

endmodule

`default_nettype wire

>>> rtl/core/tbpt_dp.sv
// Datapath: button table, flags, slot scan counter, hit test and event registers.
`default_nettype none

module tbpt_dp #(
	parameter int NUM_BUTTONS = tbpt_pkg::NUM_BUTTONS_DEF,
	parameter int COORD_BITS  = tbpt_pkg::COORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tbpt_pkg::ctrl_cmd_t        cmd_i,
	output tbpt_pkg::dp_status_t            status_o,
	input  wire logic [tbpt_pkg::CMD_W-1:0] cmd,
	input  wire logic [tbpt_pkg::BTN_W-1:0] button_index,
	input  wire logic [COORD_BITS-1:0]      touch_x,
	input  wire logic [COORD_BITS-1:0]      touch_y,
	input  wire logic [COORD_BITS-1:0]      rect_width,
	input  wire logic [COORD_BITS-1:0]      rect_height,
	input  wire logic                       slot_enabled,
	input  wire logic                       out_stall,
	output logic                            out_valid,
	output logic                            event_kind,
	output logic [tbpt_pkg::BTN_W-1:0]      event_button,
	output logic                            last_event
);
	import tbpt_pkg::*;

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	logic [COORD_BITS-1:0]  left_q [NUM_BUTTONS];
	logic [COORD_BITS-1:0]  top_q  [NUM_BUTTONS];
	logic [COORD_BITS-1:0]  w_q    [NUM_BUTTONS];
	logic [COORD_BITS-1:0]  h_q    [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] valid_q, pressed_q, touched_q;

	logic                   is_end_q;
	logic [COORD_BITS-1:0]  x_q, y_q;
	logic [IDX_W-1:0]       slot_q;

	logic                   hold_valid_q;
	logic                   hold_kind_q;
	logic [BTN_W-1:0]       hold_btn_q;

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [BTN_W-1:0]       out_btn_q;
	logic                   out_last_q;

	logic                   define_ok;
	logic [IDX_W-1:0]       wr_idx;
	logic [COORD_BITS:0]    right_edge, bottom_edge;
	logic                   hit, touch_hit, ev, out_free, push;

	assign define_ok = 32'(button_index) < NUM_BUTTONS;
	assign wr_idx    = IDX_W'(button_index);

	// half-open bounds, sums one bit wider so they never wrap
	assign right_edge  = {1'b0, left_q[slot_q]} + {1'b0, w_q[slot_q]};
	assign bottom_edge = {1'b0, top_q[slot_q]} + {1'b0, h_q[slot_q]};
	assign hit = (x_q >= left_q[slot_q]) && ({1'b0, x_q} < right_edge) &&
	             (y_q >= top_q[slot_q])  && ({1'b0, y_q} < bottom_edge);

	assign touch_hit = valid_q[slot_q] && hit;
	assign ev = is_end_q ? (valid_q[slot_q] && pressed_q[slot_q] && !touched_q[slot_q])
	                     : (touch_hit && !pressed_q[slot_q]);

	assign out_free = !out_valid_q || !out_stall;
	assign push     = (cmd_i.step && ev && hold_valid_q) || cmd_i.flush;

	assign status_o.ev         = ev;
	assign status_o.hold_valid = hold_valid_q;
	assign status_o.out_free   = out_free;
	assign status_o.last_slot  = slot_q == IDX_W'(NUM_BUTTONS - 1);

	// rectangle table: only read for enabled slots, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_i.write_slot && define_ok) begin
			left_q[wr_idx] <= touch_x;
			top_q[wr_idx]  <= touch_y;
			w_q[wr_idx]    <= rect_width;
			h_q[wr_idx]    <= rect_height;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load_item) begin
			is_end_q <= (cmd == CMD_END);
			x_q      <= touch_x;
			y_q      <= touch_y;
		end
		if (cmd_i.step && ev) begin
			hold_kind_q <= is_end_q ? EV_RELEASE : EV_PRESS;
			hold_btn_q  <= BTN_W'(slot_q);
		end
		if (push) begin
			out_kind_q <= hold_kind_q;
			out_btn_q  <= hold_btn_q;
			out_last_q <= cmd_i.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			pressed_q    <= '0;
			touched_q    <= '0;
			slot_q       <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd_i.write_slot && define_ok) begin
				valid_q[wr_idx]   <= slot_enabled;
				pressed_q[wr_idx] <= 1'b0;
			end
			if (cmd_i.load_item)
				slot_q <= '0;
			if (cmd_i.step) begin
				if (!status_o.last_slot)
					slot_q <= slot_q + 1'b1;
				if (is_end_q) begin
					if (ev)
						pressed_q[slot_q] <= 1'b0;
				end else if (touch_hit) begin
					touched_q[slot_q] <= 1'b1;
					pressed_q[slot_q] <= 1'b1;
				end
				if (ev)
					hold_valid_q <= 1'b1;
			end
			if (cmd_i.flush)
				hold_valid_q <= 1'b0;
			if (cmd_i.finish && is_end_q)
				touched_q <= '0;
			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_kind_q;
	assign event_button = out_btn_q;
	assign last_event   = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/tbpt_ctrl.sv
// Controller: item acceptance and slot scan sequencing.
`default_nettype none

module tbpt_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [tbpt_pkg::CMD_W-1:0] cmd,
	output logic                            in_stall,
	input  wire tbpt_pkg::dp_status_t       status_i,
	output tbpt_pkg::ctrl_cmd_t             cmd_o
);
	import tbpt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd_o   = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_DEFINE: cmd_o.write_slot = 1'b1;
						CMD_TOUCH, CMD_END: begin
							cmd_o.load_item = 1'b1;
							state_d         = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// a second event needs the held one moved to the output first
				if (!(status_i.ev && status_i.hold_valid && !status_i.out_free)) begin
					cmd_o.step = 1'b1;
					if (status_i.last_slot)
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status_i.hold_valid) begin
					cmd_o.finish = 1'b1;
					state_d      = ST_IDLE;
				end else if (status_i.out_free) begin
					cmd_o.flush  = 1'b1;
					cmd_o.finish = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != ST_IDLE;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the touch button press tracker.
`timescale 1ns / 100ps

module tb_top;
	import tbpt_pkg::*;

	localparam int NB = NUM_BUTTONS_DEF;
	localparam int CW = COORD_BITS_DEF;
	localparam int CMAX = (1 << CW) - 1;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int PREDICTED = -1;
	localparam int MAX_PRINTS = 40;
	localparam int ITEMS_PER_PHASE = 50;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [BTN_W-1:0] slot;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] w;
		logic [CW-1:0] h;
		logic en;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [BTN_W-1:0] btn;
		logic last;
	} event_t;

	typedef struct packed {
		item_t it;
		int typed_n;
		event_t typed_ev;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] cmd;
	logic [BTN_W-1:0] button_index;
	logic [CW-1:0] touch_x;
	logic [CW-1:0] touch_y;
	logic [CW-1:0] rect_width;
	logic [CW-1:0] rect_height;
	logic slot_enabled;
	logic out_valid;
	logic out_stall = 1'b0;
	logic event_kind;
	logic [BTN_W-1:0] event_button;
	logic last_event;

	// predictor state
	logic [CW-1:0] btn_left [NB];
	logic [CW-1:0] btn_top [NB];
	logic [CW-1:0] btn_w [NB];
	logic [CW-1:0] btn_h [NB];
	logic [NB-1:0] enabled_mask;
	logic [NB-1:0] held_mask;
	logic [NB-1:0] seen_mask;

	event_t item_events[$];
	event_t pending_events[$];
	row_t script[$];
	int fail_count;
	int idle_pct;
	int stall_pct;

	touch_button_press_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.button_index(button_index),
		.touch_x(touch_x),
		.touch_y(touch_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.slot_enabled(slot_enabled),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.event_button(event_button),
		.last_event(last_event)
	);

	always #2 clk = ~clk;

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// Work out the events one transfer causes and update the button table.
	function automatic void track_item(input item_t it);
		logic [CW:0] right;
		logic [CW:0] bottom;
		event_t ev;
		item_events.delete();
		case (it.op)
			CMD_DEFINE: begin
				btn_left[it.slot] = it.x;
				btn_top[it.slot] = it.y;
				btn_w[it.slot] = it.w;
				btn_h[it.slot] = it.h;
				enabled_mask[it.slot] = it.en;
				held_mask[it.slot] = 1'b0;
			end
			CMD_TOUCH: begin
				for (int i = 0; i < NB; i++) begin
					// one bit wider so the far edge never wraps
					right = {1'b0, btn_left[i]} + {1'b0, btn_w[i]};
					bottom = {1'b0, btn_top[i]} + {1'b0, btn_h[i]};
					if (enabled_mask[i] && it.x >= btn_left[i] && {1'b0, it.x} < right &&
							it.y >= btn_top[i] && {1'b0, it.y} < bottom) begin
						seen_mask[i] = 1'b1;
						if (!held_mask[i]) begin
							held_mask[i] = 1'b1;
							item_events.push_back('{EV_PRESS, BTN_W'(i), 1'b0});
						end
					end
				end
			end
			CMD_END: begin
				for (int i = 0; i < NB; i++) begin
					if (enabled_mask[i] && held_mask[i] && !seen_mask[i]) begin
						held_mask[i] = 1'b0;
						item_events.push_back('{EV_RELEASE, BTN_W'(i), 1'b0});
					end
				end
				seen_mask = '0;
			end
			default: begin
			end
		endcase
		if (item_events.size() > 0) begin
			ev = item_events.pop_back();
			ev.last = 1'b1;
			item_events.push_back(ev);
		end
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] op, input int slot, input int x,
			input int y, input int w, input int h, input int en, input int n,
			input logic kind, input int btn);
		row_t r;
		r.it = '{op, BTN_W'(slot), CW'(x), CW'(y), CW'(w), CW'(h), en[0]};
		r.typed_n = n;
		r.typed_ev = '{kind, BTN_W'(btn), 1'b1};
		script.push_back(r);
	endfunction

	// Random item: mostly defines, aimed touches and scan ends, with noise in
	// the fields an item does not use.
	function automatic item_t pick_item();
		item_t it;
		int r;
		int s;
		int px;
		int py;
		it.op = CMD_TOUCH;
		it.slot = BTN_W'($urandom);
		it.x = CW'($urandom);
		it.y = CW'($urandom);
		it.w = CW'($urandom);
		it.h = CW'($urandom);
		it.en = 1'($urandom);
		r = $urandom_range(99);
		if (r < 12) begin
			it.op = CMD_DEFINE;
			it.en = ($urandom_range(9) != 0);
			case ($urandom_range(3))
				0: begin
				end
				1: begin
					it.w = CW'($urandom_range(1, 300));
					it.h = CW'($urandom_range(1, 300));
				end
				2: begin
					it.x = CW'($urandom_range(CMAX - 200, CMAX));
					it.y = CW'($urandom_range(CMAX - 200, CMAX));
				end
				default: begin
					if ($urandom_range(1))
						it.w = '0;
					else
						it.h = '0;
				end
			endcase
		end else if (r < 30) begin
			it.op = CMD_END;
		end else if (r < 33) begin
			it.op = CMD_SPARE;
		end else if (r < 85) begin
			s = $urandom_range(NB - 1);
			if (enabled_mask[s] && btn_w[s] != 0 && btn_h[s] != 0) begin
				px = int'(btn_left[s]) + $urandom_range(int'(btn_w[s]) - 1);
				py = int'(btn_top[s]) + $urandom_range(int'(btn_h[s]) - 1);
				it.x = CW'((px > CMAX) ? CMAX : px);
				it.y = CW'((py > CMAX) ? CMAX : py);
			end
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input int typed_n, input event_t typed_ev);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		cmd <= it.op;
		button_index <= it.slot;
		touch_x <= it.x;
		touch_y <= it.y;
		rect_width <= it.w;
		rect_height <= it.h;
		slot_enabled <= it.en;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		track_item(it);
		if (typed_n == PREDICTED) begin
			foreach (item_events[j])
				pending_events.push_back(item_events[j]);
		end else if (typed_n == 1) begin
			pending_events.push_back(typed_ev);
		end
	endtask

	task automatic drain_events();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		event_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d button %0d last %0d",
					event_kind, event_button, last_event));
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
				if (event_button !== want.btn)
					report_mismatch($sformatf("event_button %0d, want %0d", event_button,
						want.btn));
				if (last_event !== want.last)
					report_mismatch($sformatf("last_event %0d, want %0d", last_event, want.last));
			end
		end
	end

	initial begin
		int idle_tab [4];
		int stall_tab [4];
		int sent;
		item_t it;
		event_t none_ev;
		idle_tab = '{0, 87, 0, 12};
		stall_tab = '{0, 0, 87, 12};
		none_ev = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_DEFINE;
		button_index = '0;
		touch_x = '0;
		touch_y = '0;
		rect_width = '0;
		rect_height = '0;
		slot_enabled = 1'b0;
		fail_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < NB; i++) begin
			btn_left[i] = '0;
			btn_top[i] = '0;
			btn_w[i] = '0;
			btn_h[i] = '0;
		end
		enabled_mask = '0;
		held_mask = '0;
		seen_mask = '0;

		// empty table after reset, full-screen button, edges, empty and disabled slots
		add_row(CMD_TOUCH, 0, 0, 0, 0, 0, 0, 0, EV_PRESS, 0);
		add_row(CMD_END, 7, CMAX, CMAX, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_SPARE, 5, 1234, 2345, 77, 88, 1, 0, EV_PRESS, 0);
		add_row(CMD_DEFINE, 0, 0, 0, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 3, 0, 0, CMAX, CMAX, 1, 1, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, CMAX - 1, CMAX - 1, 0, 0, 0, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, CMAX, CMAX, 0, 0, 0, 0, EV_PRESS, 0);
		add_row(CMD_END, 0, 0, 0, 0, 0, 0, 0, EV_PRESS, 0);
		add_row(CMD_END, 0, 0, 0, 0, 0, 0, 1, EV_RELEASE, 0);
		add_row(CMD_DEFINE, 7, CMAX, CMAX, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, CMAX, CMAX, 0, 0, 0, 1, EV_PRESS, 7);
		add_row(CMD_DEFINE, 3, 100, 200, 0, 50, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, 100, 200, 0, 0, 0, 1, EV_PRESS, 0);
		add_row(CMD_DEFINE, 5, 10, 10, 20, 20, 0, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, 15, 15, 0, 0, 0, 0, EV_PRESS, 0);
		add_row(CMD_DEFINE, 1, 0, 0, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_DEFINE, 2, 0, 0, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, 50, 50, 0, 0, 0, PREDICTED, EV_PRESS, 0);
		add_row(CMD_DEFINE, 0, 0, 0, CMAX, CMAX, 1, 0, EV_PRESS, 0);
		add_row(CMD_END, 0, 0, 0, 0, 0, 0, PREDICTED, EV_PRESS, 0);
		add_row(CMD_END, 0, 0, 0, 0, 0, 0, PREDICTED, EV_PRESS, 0);
		add_row(CMD_DEFINE, 4, CMAX, 0, 1, 1, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, CMAX, 0, 0, 0, 0, 1, EV_PRESS, 4);
		add_row(CMD_DEFINE, 6, 300, 300, 100, 0, 1, 0, EV_PRESS, 0);
		add_row(CMD_TOUCH, 0, 350, 300, 0, 0, 0, PREDICTED, EV_PRESS, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[k])
			send_item(script[k].it, script[k].typed_n, script[k].typed_ev);
		// hold off until every event of the directed part is out
		drain_events();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				it = pick_item();
				send_item(it, PREDICTED, none_ev);
				if (it.op != CMD_SPARE)
					sent++;
			end
			drain_events();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tbpt_pkg.sv
rtl/core/tbpt_dp.sv
rtl/core/tbpt_ctrl.sv
rtl/core/touch_button_press_tracker.sv
verif/tb_top.sv
